FILE: hw/rtl/assert_macros.svh
// assertion macros for the checker file cdd_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/cdd_pkg.sv
`timescale 1ns / 1ps
// shared constants and control types for the cepstral delta block
// no dependencies
package cdd_pkg;

    // frames kept per coefficient position
    localparam int HIST_FRAMES = 7;
    // result lag in frames, also the earliest frame offset of a flush
    localparam int LAG = 3;
    // saturation point of the completed-frame counter
    localparam int FS_MAX = 4;
    // fixed field widths
    localparam int IDX_W = 4;
    localparam int FRAME_W = 16;
    localparam int FS_W = 3;
    localparam int HEAD_W = 3;
    localparam int BOFS_W = 2;
    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;
    localparam int Q_CW = 3;

    typedef logic [HIST_FRAMES-1:0] t_lanes;

    // control part of one queued item
    typedef struct packed {
        logic               fin;
        logic               frame_end;
        logic [BOFS_W-1:0]  b_first;
        logic [FRAME_W-1:0] frame;
        logic [IDX_W-1:0]   idx;
    } t_ctl;

endpackage

FILE: hw/rtl/cdd_front.sv
`timescale 1ns / 1ps
// front end: accepts coefficients, keeps frame state and the history memory,
// aligns the seven frames of a position and hands them to the queue; uses cdd_pkg
module cdd_front #(
    parameter int NUM_COEF   = 13,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [COEF_WIDTH-1:0]                     i_value,
    input  logic [cdd_pkg::IDX_W-1:0]                 i_index,
    input  logic                                      i_final,
    input  logic [cdd_pkg::Q_CW-1:0]                  i_q_count,
    output logic                                      o_push,
    output cdd_pkg::t_ctl                             o_push_ctl,
    output logic [cdd_pkg::HIST_FRAMES*COEF_WIDTH-1:0] o_push_row
);

    localparam int AW    = (NUM_COEF > 1) ? $clog2(NUM_COEF) : 1;
    localparam int ROW_W = cdd_pkg::HIST_FRAMES * COEF_WIDTH;

    // history memory: one row per coefficient position, one lane per ring slot
    logic [ROW_W-1:0] mem [NUM_COEF];

    logic [cdd_pkg::FS_W-1:0]    r_fs, n_fs;
    logic [cdd_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic [cdd_pkg::HEAD_W-1:0]  r_head, n_head;

    logic                        r_b_valid;
    cdd_pkg::t_ctl               r_b_ctl;
    logic [COEF_WIDTH-1:0]       r_b_val;
    cdd_pkg::t_lanes             r_b_mask;
    logic [cdd_pkg::HEAD_W-1:0]  r_b_head;
    logic [ROW_W-1:0]            r_rd_row;

    logic                        in_range;
    logic                        frame_end;
    logic                        act;
    logic                        fs_ge3;
    logic                        has_res;
    logic [AW-1:0]               addr;
    cdd_pkg::t_lanes             wmask;
    logic [cdd_pkg::Q_CW-1:0]    fill;
    logic [ROW_W-1:0]            merged;

    // credit check: queued items plus the one in flight must leave a slot
    assign fill    = i_q_count + cdd_pkg::Q_CW'(r_b_valid);
    assign o_ready = (fill < cdd_pkg::Q_CW'(cdd_pkg::Q_DEPTH));

    // classify the item
    assign in_range  = (32'(i_index) < 32'(NUM_COEF));
    assign frame_end = (32'(i_index) == 32'(NUM_COEF - 1));
    assign act       = i_valid & o_ready & in_range;
    assign fs_ge3    = (r_fs >= cdd_pkg::FS_W'(cdd_pkg::LAG));
    assign has_res   = i_final | fs_ge3;
    assign addr      = AW'(i_index);
    // first frame of an utterance fills every slot, which clamps the start
    assign wmask     = (r_fs == '0) ? '1 : cdd_pkg::t_lanes'(1) << r_head;

    // history write and read-before-write of the same row
    always_ff @(posedge i_clk) begin
        if (act) begin
            r_rd_row <= mem[addr];
            for (int s = 0; s < cdd_pkg::HIST_FRAMES; s++) begin
                if (wmask[s]) begin
                    mem[addr][s*COEF_WIDTH +: COEF_WIDTH] <= i_value;
                end
            end
        end
    end

    // frame counters, advanced on the last coefficient of a frame, cleared on a final one
    always_comb begin
        n_fs    = r_fs;
        n_frame = r_frame;
        n_head  = r_head;
        if (act && frame_end) begin
            if (i_final) begin
                n_fs    = '0;
                n_frame = '0;
                n_head  = '0;
            end else begin
                if (r_fs < cdd_pkg::FS_W'(cdd_pkg::FS_MAX)) begin
                    n_fs = r_fs + 1'b1;
                end
                n_frame = r_frame + 1'b1;
                n_head  = (r_head == cdd_pkg::HEAD_W'(cdd_pkg::HIST_FRAMES - 1)) ?
                          '0 : r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs      <= '0;
            r_frame   <= '0;
            r_head    <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_fs      <= n_fs;
            r_frame   <= n_frame;
            r_head    <= n_head;
            r_b_valid <= act & has_res;
        end
    end

    // item details that travel alongside the memory read
    always_ff @(posedge i_clk) begin
        if (act) begin
            r_b_ctl.fin       <= i_final;
            r_b_ctl.frame_end <= frame_end;
            r_b_ctl.b_first   <= fs_ge3 ? cdd_pkg::BOFS_W'(cdd_pkg::LAG) :
                                          r_fs[cdd_pkg::BOFS_W-1:0];
            r_b_ctl.frame     <= r_frame;
            r_b_ctl.idx       <= i_index;
            r_b_val           <= i_value;
            r_b_mask          <= wmask;
            r_b_head          <= r_head;
        end
    end

    // merge the new value and rotate so that lane k holds frame offset -k
    always_comb begin
        logic [cdd_pkg::HEAD_W:0]   v_tmp;
        logic [cdd_pkg::HEAD_W-1:0] v_slot;
        merged = '0;
        for (int k = 0; k < cdd_pkg::HIST_FRAMES; k++) begin
            v_tmp = {1'b0, r_b_head} + (cdd_pkg::HEAD_W+1)'(cdd_pkg::HIST_FRAMES - k);
            if (v_tmp >= (cdd_pkg::HEAD_W+1)'(cdd_pkg::HIST_FRAMES)) begin
                v_tmp = v_tmp - (cdd_pkg::HEAD_W+1)'(cdd_pkg::HIST_FRAMES);
            end
            v_slot = v_tmp[cdd_pkg::HEAD_W-1:0];
            merged[k*COEF_WIDTH +: COEF_WIDTH] = r_b_mask[v_slot] ? r_b_val :
                r_rd_row[v_slot*COEF_WIDTH +: COEF_WIDTH];
        end
    end

    assign o_push     = r_b_valid;
    assign o_push_ctl = r_b_ctl;
    assign o_push_row = merged;

endmodule

FILE: hw/rtl/cdd_queue.sv
`timescale 1ns / 1ps
// short queue of aligned history rows between front and back
// uses cdd_pkg
module cdd_queue #(
    parameter int ROW_W = 112
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  cdd_pkg::t_ctl            i_ctl,
    input  logic [ROW_W-1:0]         i_row,
    input  logic                     i_pop,
    output cdd_pkg::t_ctl            o_ctl,
    output logic [ROW_W-1:0]         o_row,
    output logic [cdd_pkg::Q_CW-1:0] o_count
);

    cdd_pkg::t_ctl              r_ctl [cdd_pkg::Q_DEPTH];
    logic [ROW_W-1:0]           r_row [cdd_pkg::Q_DEPTH];
    logic [cdd_pkg::Q_AW-1:0]   r_wr, r_rd;
    logic [cdd_pkg::Q_CW-1:0]   r_count;

    // storage, written at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr] <= i_ctl;
            r_row[r_wr] <= i_row;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + cdd_pkg::Q_CW'(i_push) - cdd_pkg::Q_CW'(i_pop);
        end
    end

    assign o_ctl   = r_ctl[r_rd];
    assign o_row   = r_row[r_rd];
    assign o_count = r_count;

endmodule

FILE: hw/rtl/cdd_back.sv
`timescale 1ns / 1ps
// back end: walks the frames owed by each queued item, forms static, delta and
// double delta, and holds them in the output register; uses cdd_pkg
module cdd_back #(
    parameter int COEF_WIDTH = 16,
    parameter int OUT_TW     = 72
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [cdd_pkg::Q_CW-1:0]                   i_q_count,
    input  cdd_pkg::t_ctl                              i_ctl,
    input  logic [cdd_pkg::HIST_FRAMES*COEF_WIDTH-1:0] i_row,
    output logic                                       o_pop,
    output logic                                       o_tvalid,
    input  logic                                       i_tready,
    output logic [OUT_TW-1:0]                          o_tdata,
    output logic                                       o_tlast,
    output logic                                       o_tuser
);

    localparam int W    = COEF_WIDTH;
    localparam int O_D  = W;
    localparam int O_DD = 2 * W + 1;
    localparam int O_IX = 3 * W + 3;
    localparam int O_FN = 3 * W + 3 + cdd_pkg::IDX_W;

    logic                          r_mid, n_mid;
    logic [cdd_pkg::BOFS_W-1:0]    r_b, n_b;
    logic                          r_o_valid;
    logic [W-1:0]                  r_o_static;
    logic [W:0]                    r_o_delta;
    logic [W+1:0]                  r_o_dd;
    logic [cdd_pkg::IDX_W-1:0]     r_o_idx;
    logic [cdd_pkg::FRAME_W-1:0]   r_o_frame;
    logic                          r_o_last;
    logic                          r_o_utt;

    logic signed [W-1:0]           lane [cdd_pkg::HIST_FRAMES];
    logic [cdd_pkg::BOFS_W-1:0]    b_sel;
    logic [cdd_pkg::HEAD_W-1:0]    bx, ix_p1, ix_p2, ix_p3, ix_m1, ix_m2, ix_m3;
    logic signed [W:0]             delta, diff_a, diff_b;
    logic signed [W+1:0]           ddelta;
    logic                          q_valid, out_free, take, last;

    // split the aligned row, lane k is frame offset -k
    for (genvar k = 0; k < cdd_pkg::HIST_FRAMES; k++) begin : g_lane
        assign lane[k] = i_row[k*W +: W];
    end

    // frame offset of the result now being formed
    assign b_sel = r_mid ? r_b : i_ctl.b_first;
    assign bx    = cdd_pkg::HEAD_W'(b_sel);
    assign ix_p1 = bx + 3'd1;
    assign ix_p2 = bx + 3'd2;
    assign ix_p3 = bx + 3'd3;
    // offsets past the newest frame clamp to it
    assign ix_m1 = (bx >= 3'd1) ? bx - 3'd1 : '0;
    assign ix_m2 = (bx >= 3'd2) ? bx - 3'd2 : '0;
    assign ix_m3 = (bx >= 3'd3) ? bx - 3'd3 : '0;

    // differences, widened so nothing wraps
    assign delta  = {lane[ix_m2][W-1], lane[ix_m2]} - {lane[ix_p2][W-1], lane[ix_p2]};
    assign diff_a = {lane[ix_m3][W-1], lane[ix_m3]} - {lane[ix_p1][W-1], lane[ix_p1]};
    assign diff_b = {lane[ix_m1][W-1], lane[ix_m1]} - {lane[ix_p3][W-1], lane[ix_p3]};
    assign ddelta = {diff_a[W], diff_a} - {diff_b[W], diff_b};

    assign q_valid  = (i_q_count != '0);
    assign out_free = !r_o_valid || i_tready;
    assign take     = q_valid && out_free;
    assign last     = !i_ctl.fin || (b_sel == '0);
    assign o_pop    = take && last;

    // step through the owed frames, oldest first
    always_comb begin
        n_mid = r_mid;
        n_b   = r_b;
        if (take) begin
            if (last) begin
                n_mid = 1'b0;
            end else begin
                n_mid = 1'b1;
                n_b   = b_sel - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid     <= 1'b0;
            r_b       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_mid     <= n_mid;
            r_b       <= n_b;
            r_o_valid <= take || (r_o_valid && !i_tready);
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_static <= lane[bx];
            r_o_delta  <= delta;
            r_o_dd     <= ddelta;
            r_o_idx    <= i_ctl.idx;
            r_o_frame  <= i_ctl.frame - cdd_pkg::FRAME_W'(b_sel);
            r_o_last   <= last;
            r_o_utt    <= last && i_ctl.fin && i_ctl.frame_end;
        end
    end

    // pack the result transfer
    always_comb begin
        o_tdata                                  = '0;
        o_tdata[W-1:0]                           = r_o_static;
        o_tdata[O_D +: W+1]                      = r_o_delta;
        o_tdata[O_DD +: W+2]                     = r_o_dd;
        o_tdata[O_IX +: cdd_pkg::IDX_W]          = r_o_idx;
        o_tdata[O_FN +: cdd_pkg::FRAME_W]        = r_o_frame;
    end

    assign o_tvalid = r_o_valid;
    assign o_tlast  = r_o_last;
    assign o_tuser  = r_o_utt;

endmodule

FILE: hw/rtl/cepstral_delta_double_delta.sv
`timescale 1ns / 1ps
// an input item passes the front stage register, the queue and the output register
// throughput: one input item per cycle outside the final frame while the queue has room,
// one result per cycle while the output is not stalled; a final-frame item gives one to
// four results; the back end's walk then paces input, the queue only hides bursts
// reset: synchronous active low, clears frame counters, queue and output valid;
// the history memory is not cleared, the first frame of each utterance fills it
module cepstral_delta_double_delta #(
    parameter int NUM_COEF   = 13,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // coef_value, coef_index, zero pad
    input  logic [((COEF_WIDTH+cdd_pkg::IDX_W+7)/8)*8-1:0] s_axis_tdata,
    // final_frame
    input  logic                                     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // static_value, delta_value, double_delta_value, out_coef_index,
    // out_frame_number, zero pad
    output logic [((3*COEF_WIDTH+3+cdd_pkg::IDX_W+cdd_pkg::FRAME_W+7)/8)*8-1:0] m_axis_tdata,
    // run_last
    output logic                                     m_axis_tlast,
    // utterance_end
    output logic                                     m_axis_tuser
);

    localparam int ROW_W  = cdd_pkg::HIST_FRAMES * COEF_WIDTH;
    localparam int OUT_TW = ((3*COEF_WIDTH+3+cdd_pkg::IDX_W+cdd_pkg::FRAME_W+7)/8)*8;

    logic                     push, pop;
    cdd_pkg::t_ctl            push_ctl, head_ctl;
    logic [ROW_W-1:0]         push_row, head_row;
    logic [cdd_pkg::Q_CW-1:0] q_count;

    // accept, classify and align
    cdd_front #(
        .NUM_COEF   (NUM_COEF),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_value    (s_axis_tdata[COEF_WIDTH-1:0]),
        .i_index    (s_axis_tdata[COEF_WIDTH +: cdd_pkg::IDX_W]),
        .i_final    (s_axis_tuser),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_push_ctl (push_ctl),
        .o_push_row (push_row)
    );

    // decoupling queue
    cdd_queue #(
        .ROW_W (ROW_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ctl   (push_ctl),
        .i_row   (push_row),
        .i_pop   (pop),
        .o_ctl   (head_ctl),
        .o_row   (head_row),
        .o_count (q_count)
    );

    // result generation and output register
    cdd_back #(
        .COEF_WIDTH (COEF_WIDTH),
        .OUT_TW     (OUT_TW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_count (q_count),
        .i_ctl     (head_ctl),
        .i_row     (head_row),
        .o_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast),
        .o_tuser   (m_axis_tuser)
    );

endmodule

FILE: hw/rtl/cdd_checker.sv
`timescale 1ns / 1ps
// port-level checks for the cepstral delta block, bound to the top level
// depends on assert_macros.svh and cdd_pkg
`include "assert_macros.svh"

module cdd_checker #(
    parameter int NUM_COEF   = 13,
    parameter int COEF_WIDTH = 16
) (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     m_axis_tvalid,
    input logic                                     m_axis_tready,
    input logic [((3*COEF_WIDTH+3+cdd_pkg::IDX_W+cdd_pkg::FRAME_W+7)/8)*8-1:0] m_axis_tdata,
    input logic                                     m_axis_tlast,
    input logic                                     m_axis_tuser
);

    localparam int O_IX = 3 * COEF_WIDTH + 3;

    logic [cdd_pkg::IDX_W-1:0] out_idx;

    assign out_idx = m_axis_tdata[O_IX +: cdd_pkg::IDX_W];

    // a stalled result stays offered and unchanged
    `ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_data_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // utterance end only closes the run of its item
    `ASSERT_IMPLIES(a_end_is_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

    // results only for coefficient positions that exist
    `ASSERT_IMPLIES(a_idx_range, i_clk, i_rst_n, m_axis_tvalid, 32'(out_idx) < 32'(NUM_COEF))

endmodule

bind cepstral_delta_double_delta cdd_checker #(
    .NUM_COEF   (NUM_COEF),
    .COEF_WIDTH (COEF_WIDTH)
) u_cdd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
